/* rtl/assert_macros.svh */
// assertion macros shared by the tone mapper rtl
// expects clk and rst_n in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ltm_pkg.sv */
// shared constants for the logarithmic tone mapper
// no dependencies
package ltm_pkg;

    localparam int INTENSITY_BITS    = 32;
    localparam int FRACTION_BITS     = 16;
    localparam int LOG_FRACTION_BITS = 16;

    // 1 + x - min needs one extra bit
    localparam int VAL_W     = INTENSITY_BITS + 1;
    localparam int TOP_W     = $clog2(VAL_W);
    localparam int MANT_W    = VAL_W - 1;
    localparam int LOG_INT_W = $clog2(INTENSITY_BITS - FRACTION_BITS + 1);
    localparam int LOG_W     = LOG_INT_W + LOG_FRACTION_BITS;
    localparam int ITER_W    = $clog2(LOG_FRACTION_BITS);

    // output scaling by 255
    localparam int BYTE_W    = 8;
    localparam int QUOT_W    = BYTE_W + 1;
    localparam int NUM_W     = LOG_W + BYTE_W;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam int CHANNELS  = 3;
    localparam int CH_W      = $clog2(CHANNELS);

    // pass codes
    localparam logic ACT_GATHER = 1'b0;
    localparam logic ACT_MAP    = 1'b1;

endpackage

/* rtl/ltm_if.sv */
// pixel and result channel interfaces for the tone mapper
// depends on ltm_pkg
interface ltm_pix_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic                                first_of_pass;
    logic [ltm_pkg::INTENSITY_BITS-1:0] red_in;
    logic [ltm_pkg::INTENSITY_BITS-1:0] green_in;
    logic [ltm_pkg::INTENSITY_BITS-1:0] blue_in;

    modport source (output valid, action, first_of_pass, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, first_of_pass, red_in, green_in, blue_in,
                    output ready);
endinterface

interface ltm_byte_if;
    logic                        valid;
    logic                        ready;
    logic [ltm_pkg::BYTE_W-1:0] red_out;
    logic [ltm_pkg::BYTE_W-1:0] green_out;
    logic [ltm_pkg::BYTE_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* rtl/log_tone_mapper.sv */
// a gather transfer is absorbed in its accepting cycle; a map pixel is worked channel by channel
// and its result loaded from the done state, no new pixel being taken until after the load; each
// channel skips the work when flat and the divide when the range logs to zero, else it makes
// two runs of the shared log unit (normalize, 16 squaring steps) and a 9 step divide
// async active-low reset clears the sequencer, the output valid and the statistics
// (minimum all ones, maximum zero)
`include "assert_macros.svh"

module log_tone_mapper
(
    input  logic         clk,
    input  logic         rst_n,
    ltm_pix_if.sink      pixel,
    ltm_byte_if.source   tone
);

    // per-pixel sequencer over the three channels
    typedef enum logic [2:0] {S_IDLE, S_PREP, S_NUM, S_DEN, S_DIV, S_NEXT, S_DONE} state_t;

    localparam int IW = ltm_pkg::INTENSITY_BITS;
    localparam logic [ltm_pkg::CH_W-1:0] CH_LAST = ltm_pkg::CH_W'(ltm_pkg::CHANNELS - 1);

    state_t                          state_reg, state_next;
    logic [ltm_pkg::CH_W-1:0]       ch_reg, ch_next;
    logic [IW-1:0]                  pix_reg  [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  pix_next [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  low_reg  [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  low_next [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  high_reg [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  high_next[ltm_pkg::CHANNELS];
    logic [ltm_pkg::BYTE_W-1:0]     byte_reg [ltm_pkg::CHANNELS];
    logic [ltm_pkg::BYTE_W-1:0]     byte_next[ltm_pkg::CHANNELS];
    logic [ltm_pkg::BYTE_W-1:0]     out_reg  [ltm_pkg::CHANNELS];
    logic [ltm_pkg::BYTE_W-1:0]     out_next [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  range_reg, range_next;
    logic [ltm_pkg::LOG_W-1:0]      num_reg, num_next;
    logic                            log_start_reg, log_start_next;
    logic [IW-1:0]                  log_opnd_reg, log_opnd_next;
    logic                            div_start_reg, div_start_next;
    logic [ltm_pkg::LOG_W-1:0]      div_num_reg, div_num_next;
    logic [ltm_pkg::LOG_W-1:0]      div_den_reg, div_den_next;
    logic                            out_valid_reg, out_valid_next;

    logic [IW-1:0]                  pin [ltm_pkg::CHANNELS];
    logic                            take;
    logic [IW-1:0]                  cur_x, cur_lo, cur_hi;
    logic [IW:0]                    diff_x, diff_r;
    logic [IW-1:0]                  pix_off;
    logic                            flat;
    logic [IW-1:0]                  base_lo [ltm_pkg::CHANNELS];
    logic [IW-1:0]                  base_hi [ltm_pkg::CHANNELS];

    logic                            log_done;
    logic [ltm_pkg::LOG_W-1:0]      log_result;
    logic                            div_done;
    logic [ltm_pkg::BYTE_W-1:0]     div_quot;

    logic                            log_wait;
    logic                            restart_take;
    logic                            stats_equal;

    ltm_log_unit u_log
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start_reg),
        .operand (log_opnd_reg),
        .done    (log_done),
        .result  (log_result)
    );

    ltm_div_unit u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign pin[0] = pixel.red_in;
    assign pin[1] = pixel.green_in;
    assign pin[2] = pixel.blue_in;

    assign pixel.ready = (state_reg == S_IDLE);
    assign take        = pixel.valid && (state_reg == S_IDLE);

    // channel under work
    assign cur_x  = pix_reg[ch_reg];
    assign cur_lo = low_reg[ch_reg];
    assign cur_hi = high_reg[ch_reg];

    // pixel offset from minimum, clamped at zero; range and its flat check from borrow or zero
    assign diff_x  = {1'b0, cur_x} - {1'b0, cur_lo};
    assign pix_off = diff_x[IW] ? '0 : diff_x[IW-1:0];
    assign diff_r  = {1'b0, cur_hi} - {1'b0, cur_lo};
    assign flat    = diff_r[IW] || (diff_r[IW-1:0] == '0);

    // first pixel of a gather pass starts from the reset statistics
    always_comb
    begin
        for (int c = 0; c < ltm_pkg::CHANNELS; c++)
        begin
            base_lo[c] = pixel.first_of_pass ? {IW{1'b1}} : low_reg[c];
            base_hi[c] = pixel.first_of_pass ? {IW{1'b0}} : high_reg[c];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        pix_next       = pix_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        byte_next      = byte_reg;
        out_next       = out_reg;
        range_next     = range_reg;
        num_next       = num_reg;
        log_start_next = 1'b0;
        log_opnd_next  = log_opnd_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        out_valid_next = out_valid_reg;

        // result register drains independently of the sequencer
        if (tone.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (pixel.action == ltm_pkg::ACT_GATHER)
                    begin
                        for (int c = 0; c < ltm_pkg::CHANNELS; c++)
                        begin
                            low_next[c]  = (pin[c] < base_lo[c]) ? pin[c] : base_lo[c];
                            high_next[c] = (pin[c] > base_hi[c]) ? pin[c] : base_hi[c];
                        end
                    end
                    else
                    begin
                        pix_next   = pin;
                        ch_next    = '0;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                range_next = diff_r[IW-1:0];
                if (flat)
                begin
                    // flat channel or no statistics gathered
                    byte_next[ch_reg] = '0;
                    state_next        = S_NEXT;
                end
                else
                begin
                    log_start_next = 1'b1;
                    log_opnd_next  = pix_off;
                    state_next     = S_NUM;
                end
            end
            S_NUM:
            begin
                if (log_done)
                begin
                    num_next       = log_result;
                    log_start_next = 1'b1;
                    log_opnd_next  = range_reg;
                    state_next     = S_DEN;
                end
            end
            S_DEN:
            begin
                if (log_done)
                begin
                    if (log_result == '0)
                    begin
                        // range too small to show in the log
                        byte_next[ch_reg] = '0;
                        state_next        = S_NEXT;
                    end
                    else
                    begin
                        div_start_next = 1'b1;
                        div_num_next   = num_reg;
                        div_den_next   = log_result;
                        state_next     = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    byte_next[ch_reg] = div_quot;
                    state_next        = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (ch_reg == CH_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + ltm_pkg::CH_W'(1);
                    state_next = S_PREP;
                end
            end
            S_DONE:
            begin
                // wait until the previous result transfer has gone
                if (!out_valid_reg || tone.ready)
                begin
                    out_next       = byte_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            log_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < ltm_pkg::CHANNELS; c++)
            begin
                low_reg[c]  <= {IW{1'b1}};
                high_reg[c] <= {IW{1'b0}};
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            log_start_reg <= log_start_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        byte_reg     <= byte_next;
        out_reg      <= out_next;
        range_reg    <= range_next;
        num_reg      <= num_next;
        log_opnd_reg <= log_opnd_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
    end

    assign tone.valid     = out_valid_reg;
    assign tone.red_out   = out_reg[0];
    assign tone.green_out = out_reg[1];
    assign tone.blue_out  = out_reg[2];

    // terms for the checks below
    assign log_wait     = (state_reg == S_NUM) || (state_reg == S_DEN);
    assign restart_take = take && (pixel.action == ltm_pkg::ACT_GATHER) && pixel.first_of_pass;
    assign stats_equal  = (low_reg[0] == high_reg[0]) && (low_reg[1] == high_reg[1])
                          && (low_reg[2] == high_reg[2]);

    // log unit only answers while the sequencer waits for it
    `ASSERT_IMPL(a_log_done_state, log_done, log_wait, "log result outside log wait")
    // divider only answers while the sequencer waits for it
    `ASSERT_IMPL(a_div_done_state, div_done, state_reg == S_DIV, "divide result outside wait")
    // a new result is loaded only from the done state
    `ASSERT_IMPL(a_load_from_done, $rose(tone.valid), $past(state_reg == S_DONE), "stray load")
    // a restarting gather leaves min equal to max on every channel
    `ASSERT_NEXT(a_restart_stats, restart_take, stats_equal, "restart did not reset statistics")

endmodule

/* rtl/ltm_log_unit.sv */
// iterative fixed-point log2 of (1 + operand), fraction by repeated squaring
// depends on ltm_pkg; one 32x32 multiplier reused each iteration
module ltm_log_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ltm_pkg::INTENSITY_BITS-1:0] operand,
    output logic                                done,
    output logic [ltm_pkg::LOG_W-1:0]          result
);

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} state_t;

    localparam logic [ltm_pkg::VAL_W-1:0] ONE_V =
        ltm_pkg::VAL_W'(1) << ltm_pkg::FRACTION_BITS;
    localparam logic [ltm_pkg::TOP_W-1:0] TOP_INIT = ltm_pkg::TOP_W'(ltm_pkg::VAL_W - 1);
    localparam logic [ltm_pkg::TOP_W-1:0] TOP_BASE = ltm_pkg::TOP_W'(ltm_pkg::FRACTION_BITS);
    localparam logic [ltm_pkg::ITER_W-1:0] ITER_LAST =
        ltm_pkg::ITER_W'(ltm_pkg::LOG_FRACTION_BITS - 1);

    state_t                                   state_reg, state_next;
    logic [ltm_pkg::VAL_W-1:0]               v_reg, v_next;
    logic [ltm_pkg::TOP_W-1:0]               top_reg, top_next;
    logic [ltm_pkg::MANT_W-1:0]              m_reg, m_next;
    logic [ltm_pkg::LOG_FRACTION_BITS-1:0]   frac_reg, frac_next;
    logic [ltm_pkg::ITER_W-1:0]              cnt_reg, cnt_next;
    logic                                     done_reg, done_next;
    logic [ltm_pkg::LOG_W-1:0]               result_reg, result_next;

    logic [2*ltm_pkg::MANT_W-1:0]            sq;
    logic [ltm_pkg::MANT_W:0]                sq_top;
    logic [ltm_pkg::TOP_W-1:0]               top_rel;

    assign sq      = m_reg * m_reg;
    assign sq_top  = sq[2*ltm_pkg::MANT_W-1:ltm_pkg::MANT_W-1];
    assign top_rel = top_reg - TOP_BASE;

    always_comb
    begin
        state_next  = state_reg;
        v_next      = v_reg;
        top_next    = top_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    v_next     = ltm_pkg::VAL_W'(operand) + ONE_V;
                    top_next   = TOP_INIT;
                    frac_next  = '0;
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                // bring the leading one to the top, four places at a time when possible
                if (v_reg[ltm_pkg::VAL_W-1])
                begin
                    m_next     = v_reg[ltm_pkg::VAL_W-1:1];
                    cnt_next   = '0;
                    state_next = L_SQ;
                end
                else if (v_reg[ltm_pkg::VAL_W-1 -: 4] == 4'b0000)
                begin
                    v_next   = v_reg << 4;
                    top_next = top_reg - ltm_pkg::TOP_W'(4);
                end
                else
                begin
                    v_next   = v_reg << 1;
                    top_next = top_reg - ltm_pkg::TOP_W'(1);
                end
            end
            L_SQ:
            begin
                frac_next = {frac_reg[ltm_pkg::LOG_FRACTION_BITS-2:0], sq_top[ltm_pkg::MANT_W]};
                m_next    = sq_top[ltm_pkg::MANT_W] ? sq_top[ltm_pkg::MANT_W:1]
                                                    : sq_top[ltm_pkg::MANT_W-1:0];
                cnt_next  = cnt_reg + ltm_pkg::ITER_W'(1);
                if (cnt_reg == ITER_LAST)
                begin
                    done_next   = 1'b1;
                    result_next = {top_rel[ltm_pkg::LOG_INT_W-1:0], frac_next};
                    state_next  = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        top_reg    <= top_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/ltm_div_unit.sv */
// restoring divider for 255*num/den, one quotient bit per cycle, saturates at 255
// depends on ltm_pkg
module ltm_div_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ltm_pkg::LOG_W-1:0]  num,
    input  logic [ltm_pkg::LOG_W-1:0]  den,
    output logic                        done,
    output logic [ltm_pkg::BYTE_W-1:0] quot
);

    typedef enum logic {D_IDLE, D_RUN} state_t;

    localparam logic [ltm_pkg::DIV_CNT_W-1:0] CNT_LAST =
        ltm_pkg::DIV_CNT_W'(ltm_pkg::QUOT_W - 1);

    state_t                               state_reg, state_next;
    logic [ltm_pkg::NUM_W-1:0]           rem_reg, rem_next;
    logic [ltm_pkg::NUM_W-1:0]           dsh_reg, dsh_next;
    logic [ltm_pkg::QUOT_W-1:0]          q_reg, q_next;
    logic [ltm_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                 done_reg, done_next;
    logic [ltm_pkg::BYTE_W-1:0]          quot_reg, quot_next;

    logic                                 fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    // 255*num as 256*num - num
                    rem_next   = {num, {ltm_pkg::BYTE_W{1'b0}}} - ltm_pkg::NUM_W'(num);
                    dsh_next   = {den, {ltm_pkg::BYTE_W{1'b0}}};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
                q_next   = {q_reg[ltm_pkg::QUOT_W-2:0], fits};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + ltm_pkg::DIV_CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    // top quotient bit set means 256 or more
                    done_next  = 1'b1;
                    quot_next  = q_next[ltm_pkg::QUOT_W-1] ? {ltm_pkg::BYTE_W{1'b1}}
                                                           : q_next[ltm_pkg::BYTE_W-1:0];
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
